@@ rtl/tglc_pkg.sv @@
// Shared types, register indices, reset values and helpers for the throttle
// gesture light controller. No dependencies; every other rtl file imports it.
package tglc_pkg;

  // field widths
  localparam int unsigned PW_W     = 12;
  localparam int unsigned MARGIN_W = 10;
  localparam int unsigned THR_W    = 13;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned PHASE_W  = 14;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 16;
  localparam int unsigned EVT_W    = 4;
  localparam int unsigned LAMP_W   = 4;

  // register indices
  localparam logic [CFG_AW-1:0] REG_CENTER     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MARGIN     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_REVERSE    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SHORT_HOLD = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FIRE_PHASE = 3'd4;
  localparam logic [CFG_AW-1:0] REG_IDLE_WAIT  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_BLINK      = 3'd6;

  // register reset values
  localparam logic [PW_W-1:0]     RST_CENTER     = 12'd1500;
  localparam logic [MARGIN_W-1:0] RST_MARGIN     = 10'd20;
  localparam logic [TIME_W-1:0]   RST_SHORT_HOLD = 16'd300;
  localparam logic [PHASE_W-1:0]  RST_FIRE_PHASE = 14'd50;
  localparam logic [TIME_W-1:0]   RST_IDLE_WAIT  = 16'd3000;
  localparam logic [TIME_W-1:0]   RST_BLINK      = 16'd500;

  localparam logic [TIME_W-1:0]   TIME_SAT       = '1;

  // lamp bit positions
  localparam int unsigned LAMP_TAIL_L  = 0;
  localparam int unsigned LAMP_TAIL_R  = 1;
  localparam int unsigned LAMP_FIRE    = 2;
  localparam int unsigned LAMP_CHASSIS = 3;

  // event bit positions
  localparam int unsigned EVT_DROP  = 0;
  localparam int unsigned EVT_BRAKE = 1;
  localparam int unsigned EVT_FIRE  = 2;
  localparam int unsigned EVT_IDLE  = 3;

  // action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  typedef struct packed {
    logic [PW_W-1:0]     center;
    logic [MARGIN_W-1:0] margin;
    logic                reverse;
    logic [TIME_W-1:0]   short_hold_ms;
    logic [PHASE_W-1:0]  fire_phase_ms;
    logic [TIME_W-1:0]   idle_wait_ms;
    logic [TIME_W-1:0]   blink_ms;
  } tglc_cfg_t;

  typedef struct packed {
    logic            action;
    logic [PW_W-1:0] pulse_width;
    logic            switch_on;
    logic            stop_blink_enable;
  } tglc_item_t;

  typedef struct packed {
    logic [LAMP_W-1:0]      lamps;
    logic signed [THR_W-1:0] throttle_value;
    logic [EVT_W-1:0]       active_events;
  } tglc_result_t;

  // saturating millisecond counter step
  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] c);
    sat_inc = (c == TIME_SAT) ? TIME_SAT : c + 1'b1;
  endfunction

  // magnitude of a throttle value
  function automatic logic [THR_W-1:0] thr_mag(input logic signed [THR_W-1:0] v);
    thr_mag = v[THR_W-1] ? THR_W'(-v) : THR_W'(v);
  endfunction

endpackage

@@ rtl/throttle_gesture_light_controller.sv @@
// Top level of the throttle gesture light controller: stream ports, input and
// result registers. Depends on tglc_pkg, tglc_cfg and tglc_core.
//
//   channel  direction  handshake          contents
//   s_*      in         s_tvalid/s_tready  pulse sample or millisecond tick
//   m_*      out        m_tvalid/m_tready  lamp drives, throttle, event flags
//   cfg_*    in         cfg_we             register index and write data
//
// One request per cycle while the receiver keeps taking results; a request goes
// into the input register, then its result into the result register after the
// single event/lamp pass, and from there it is shown on m_*.
// rst is synchronous: registers return to their reset values, all events clear.
// A stalled result holds in the result register while one more request waits
// in the input register; s_tready drops only when both are full and m_tready
// is low.
module throttle_gesture_light_controller (
  input  logic                         clk,
  input  logic                         rst,
  // stream in
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,  // pulse_width[11:0], switch_on[12],
                                                 // stop_blink_enable[13], zero[15:14]
  input  logic                         s_tuser,  // action[0]
  // stream out
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,  // tail_left[0], tail_right[1],
                                                 // fire_lamp[2], chassis_lamp[3],
                                                 // throttle_value[16:4],
                                                 // active_events[20:17], zero[23:21]
  // configuration
  input  logic                         cfg_we,
  input  logic [tglc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [tglc_pkg::CFG_DW-1:0]  cfg_wdata
);
  import tglc_pkg::*;

  tglc_cfg_t    cfg;
  tglc_item_t   in_item;
  logic         in_valid;
  logic         advance;
  tglc_result_t core_result;
  tglc_result_t out_result;

  // config registers
  tglc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake control
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action            <= s_tuser;
      in_item.pulse_width       <= s_tdata[PW_W-1:0];
      in_item.switch_on         <= s_tdata[PW_W];
      in_item.stop_blink_enable <= s_tdata[PW_W+1];
    end
  end

  // event and lamp logic
  tglc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_result <= core_result;
  end

  assign m_tdata = {3'b000, out_result.active_events, out_result.throttle_value,
                    out_result.lamps};

  // a held request moves on as soon as the result register is free
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !m_tvalid |=> m_tvalid)
    else $error("request stuck with result register empty");

endmodule

@@ rtl/tglc_cfg.sv @@
// Configuration register file for the throttle gesture light controller.
// Depends on tglc_pkg for register indices, reset values and the config struct.
module tglc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tglc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [tglc_pkg::CFG_DW-1:0]  cfg_wdata,
  output tglc_pkg::tglc_cfg_t          cfg
);
  import tglc_pkg::*;

  // register writes, unknown indices ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center        <= RST_CENTER;
      cfg.margin        <= RST_MARGIN;
      cfg.reverse       <= 1'b0;
      cfg.short_hold_ms <= RST_SHORT_HOLD;
      cfg.fire_phase_ms <= RST_FIRE_PHASE;
      cfg.idle_wait_ms  <= RST_IDLE_WAIT;
      cfg.blink_ms      <= RST_BLINK;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CENTER:     cfg.center        <= cfg_wdata[PW_W-1:0];
        REG_MARGIN:     cfg.margin        <= cfg_wdata[MARGIN_W-1:0];
        REG_REVERSE:    cfg.reverse       <= cfg_wdata[0];
        REG_SHORT_HOLD: cfg.short_hold_ms <= cfg_wdata[TIME_W-1:0];
        REG_FIRE_PHASE: cfg.fire_phase_ms <= cfg_wdata[PHASE_W-1:0];
        REG_IDLE_WAIT:  cfg.idle_wait_ms  <= cfg_wdata[TIME_W-1:0];
        REG_BLINK:      cfg.blink_ms      <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/tglc_core.sv @@
// Event detection, timers and lamp logic of the throttle gesture light controller.
// Depends on tglc_pkg; one request is processed in every cycle that step is high.
module tglc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  tglc_pkg::tglc_item_t  item,
  input  tglc_pkg::tglc_cfg_t   cfg,
  output tglc_pkg::tglc_result_t result
);
  import tglc_pkg::*;

  // state
  logic signed [THR_W-1:0] last_throttle, last_throttle_next;
  logic                    drop_active, drop_active_next;
  logic [TIME_W-1:0]       drop_elapsed, drop_elapsed_next;
  logic                    brake_active, brake_active_next;
  logic                    fire_active, fire_active_next;
  logic [TIME_W-1:0]       fire_elapsed, fire_elapsed_next;
  logic                    idle_active, idle_active_next;
  logic [TIME_W-1:0]       idle_elapsed, idle_elapsed_next;
  logic [TIME_W-1:0]       blink_elapsed, blink_elapsed_next;
  logic                    blink_phase, blink_phase_next;
  logic [LAMP_W-1:0]       lamp_levels, lamp_levels_next;

  // sample path
  logic                    is_tick;
  logic signed [THR_W-1:0] t_raw, t_new, thr;
  logic [THR_W-1:0]        mag_p, mag_thr, m_ext;
  logic signed [THR_W-1:0] m_signed;
  logic signed [THR_W:0]   diff;
  logic [THR_W:0]          mag_d;
  logic                    drop_set, brake_set, fire_set, idle_set;
  logic [TIME_W:0]         phase_x2, phase_x3;

  assign is_tick  = (item.action == ACT_TICK);
  assign t_raw    = $signed({1'b0, item.pulse_width}) - $signed({1'b0, cfg.center});
  assign t_new    = cfg.reverse ? -t_raw : t_raw;
  assign thr      = is_tick ? last_throttle : t_new;
  assign mag_thr  = thr_mag(thr);
  assign mag_p    = thr_mag(last_throttle);
  assign m_ext    = THR_W'(cfg.margin);
  assign m_signed = $signed(m_ext);
  assign diff     = (THR_W+1)'(t_new) - (THR_W+1)'(last_throttle);
  assign mag_d    = diff[THR_W] ? (THR_W+1)'(-diff) : (THR_W+1)'(diff);

  // event starts, only meaningful on a sample
  assign drop_set  = (mag_thr < mag_p) && (mag_d > (THR_W+1)'(m_ext)) && (mag_thr > m_ext);
  assign brake_set = (mag_p < m_ext) && (mag_thr > m_ext) && t_new[THR_W-1];
  assign fire_set  = (last_throttle > m_signed) && (mag_thr < m_ext);
  assign idle_set  = item.stop_blink_enable && !idle_active && (mag_thr < m_ext);

  // fire pattern phase boundaries
  assign phase_x2 = (TIME_W+1)'({cfg.fire_phase_ms, 1'b0});
  assign phase_x3 = phase_x2 + (TIME_W+1)'(cfg.fire_phase_ms);

  // timers, event starts, then the lamp service pass
  always_comb begin
    last_throttle_next = thr;
    drop_active_next   = drop_active;
    drop_elapsed_next  = drop_elapsed;
    brake_active_next  = brake_active;
    fire_active_next   = fire_active;
    fire_elapsed_next  = fire_elapsed;
    idle_active_next   = idle_active;
    idle_elapsed_next  = idle_elapsed;
    blink_elapsed_next = blink_elapsed;
    blink_phase_next   = blink_phase;
    lamp_levels_next   = lamp_levels;

    if (is_tick) begin
      drop_elapsed_next  = sat_inc(drop_elapsed);
      fire_elapsed_next  = sat_inc(fire_elapsed);
      idle_elapsed_next  = sat_inc(idle_elapsed);
      blink_elapsed_next = sat_inc(blink_elapsed);
    end else begin
      if (drop_set) begin
        drop_active_next  = 1'b1;
        drop_elapsed_next = '0;
      end
      if (brake_set) brake_active_next = 1'b1;
      if (fire_set) begin
        fire_active_next  = 1'b1;
        fire_elapsed_next = '0;
      end
      if (idle_set) begin
        idle_active_next  = 1'b1;
        idle_elapsed_next = '0;
      end
    end

    // drop hold
    if (drop_active_next) begin
      lamp_levels_next[LAMP_TAIL_L] = 1'b1;
      lamp_levels_next[LAMP_TAIL_R] = 1'b1;
      if (drop_elapsed_next >= cfg.short_hold_ms) begin
        if (!item.switch_on) lamp_levels_next[LAMP_TAIL_L] = 1'b0;
        lamp_levels_next[LAMP_TAIL_R] = 1'b0;
        drop_active_next = 1'b0;
      end
    end

    // fire on-off-on pattern
    if (fire_active_next) begin
      if ((TIME_W+1)'(fire_elapsed_next) >= phase_x3) begin
        lamp_levels_next[LAMP_FIRE] = 1'b0;
        fire_active_next = 1'b0;
      end else if ((TIME_W+1)'(fire_elapsed_next) >= phase_x2) begin
        lamp_levels_next[LAMP_FIRE] = 1'b1;
      end else if (fire_elapsed_next >= TIME_W'(cfg.fire_phase_ms)) begin
        lamp_levels_next[LAMP_FIRE] = 1'b0;
      end else begin
        lamp_levels_next[LAMP_FIRE] = 1'b1;
      end
    end

    // idle wait and chassis blinking
    if (idle_active_next) begin
      if ((mag_thr > m_ext) || !item.stop_blink_enable) begin
        idle_active_next = 1'b0;
        blink_phase_next = 1'b0;
        lamp_levels_next[LAMP_CHASSIS] = !item.stop_blink_enable && item.switch_on;
      end else if ((idle_elapsed_next >= cfg.idle_wait_ms) &&
                   (blink_elapsed_next >= cfg.blink_ms)) begin
        blink_phase_next = !blink_phase;
        lamp_levels_next[LAMP_CHASSIS] = !blink_phase;
        blink_elapsed_next = '0;
      end
    end

    // brake lamps until centre or forward
    if (brake_active_next) begin
      lamp_levels_next[LAMP_TAIL_L] = 1'b1;
      lamp_levels_next[LAMP_TAIL_R] = 1'b1;
      if ((mag_thr < m_ext) || (thr > m_signed)) begin
        if (!item.switch_on) lamp_levels_next[LAMP_TAIL_L] = 1'b0;
        lamp_levels_next[LAMP_TAIL_R] = 1'b0;
        brake_active_next = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_throttle <= '0;
      drop_active   <= 1'b0;
      drop_elapsed  <= '0;
      brake_active  <= 1'b0;
      fire_active   <= 1'b0;
      fire_elapsed  <= '0;
      idle_active   <= 1'b0;
      idle_elapsed  <= '0;
      blink_elapsed <= TIME_SAT;
      blink_phase   <= 1'b0;
      lamp_levels   <= '0;
    end else if (step) begin
      last_throttle <= last_throttle_next;
      drop_active   <= drop_active_next;
      drop_elapsed  <= drop_elapsed_next;
      brake_active  <= brake_active_next;
      fire_active   <= fire_active_next;
      fire_elapsed  <= fire_elapsed_next;
      idle_active   <= idle_active_next;
      idle_elapsed  <= idle_elapsed_next;
      blink_elapsed <= blink_elapsed_next;
      blink_phase   <= blink_phase_next;
      lamp_levels   <= lamp_levels_next;
    end
  end

  // result of the request being processed
  always_comb begin
    result.lamps          = lamp_levels_next;
    result.throttle_value = last_throttle_next;
    result.active_events  = '0;
    result.active_events[EVT_DROP]  = drop_active_next;
    result.active_events[EVT_BRAKE] = brake_active_next;
    result.active_events[EVT_FIRE]  = fire_active_next;
    result.active_events[EVT_IDLE]  = idle_active_next;
  end

  // a tick never moves the throttle
  assert property (@(posedge clk) disable iff (rst)
    step && is_tick |=> last_throttle == $past(last_throttle))
    else $error("throttle changed on a tick");

  // an active brake keeps both tail lamps lit
  assert property (@(posedge clk) disable iff (rst)
    brake_active |-> lamp_levels[LAMP_TAIL_L] && lamp_levels[LAMP_TAIL_R])
    else $error("brake active with a tail lamp off");

  // blink phase only runs while idle is active
  assert property (@(posedge clk) disable iff (rst)
    !idle_active |-> !blink_phase)
    else $error("blink phase set outside idle");

endmodule

@@ verif/tb_throttle_gesture_light_controller.sv @@
// Self-checking bench for throttle_gesture_light_controller: streams pulse samples
// and millisecond ticks, predicts every lamp/throttle/event result in-line.
// Depends on tglc_pkg and the rtl top level only.
`timescale 1ns / 100ps

module tb_throttle_gesture_light_controller;
  import tglc_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD   = 300;
  localparam int TICK_RUN    = 40;
  localparam int MAX_PRINTS  = 40;
  localparam logic [CFG_AW-1:0] REG_SPARE = 3'd7;

  typedef struct {
    tglc_item_t   req;
    bit           has_gold;
    tglc_result_t gold;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata = '0;  // pulse_width[11:0], switch_on[12],
                                      // stop_blink_enable[13], zero[15:14]
  logic                s_tuser = 1'b0; // action[0]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [23:0]         m_tdata;        // tail_left[0], tail_right[1], fire_lamp[2],
                                       // chassis_lamp[3], throttle_value[16:4],
                                       // active_events[20:17], zero[23:21]
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  throttle_gesture_light_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // predictor copy of the registers
  int c_center = 1500, c_margin = 20, c_reverse = 0;
  int c_hold = 300, c_fire_ph = 50, c_idle_wait = 3000, c_blink = 500;

  // predictor copy of the event and lamp state
  int       thr_prev = 0;
  bit       ev_drop = 0, ev_brake = 0, ev_fire = 0, ev_idle = 0;
  int       ms_drop = 0, ms_fire = 0, ms_idle = 0, ms_blink = 65535;
  bit       blink_on = 0;
  logic [LAMP_W-1:0] lamp_q = '0;

  tglc_result_t lamp_results_due[$];
  stim_row_t    stim_rows[$];

  int  sent_count = 0, results_checked = 0, err_count = 0, settings_count = 0;
  int  cycle_count = 0;
  int  idle_pct = 0, stall_pct = 0;
  int  hold_reqs = 0, hold_seen = 0, hold_left = 0;
  bit  gold_use = 1'b0;
  tglc_result_t gold_now = '0;

  // shape of the current random gesture burst
  int burst_left = 0, burst_cat = 0, burst_tick_pct = 50, burst_en_pct = 98;

  function automatic int absv(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int ms_bump(int c);
    return (c >= 65535) ? 65535 : c + 1;
  endfunction

  // one request through the event detector and the lamp pass
  function automatic tglc_result_t lamp_step(tglc_item_t r);
    tglc_result_t y;
    int t, m, p;
    m = c_margin;
    p = c_fire_ph;
    if (r.action == ACT_TICK) begin
      ms_drop  = ms_bump(ms_drop);
      ms_fire  = ms_bump(ms_fire);
      ms_idle  = ms_bump(ms_idle);
      ms_blink = ms_bump(ms_blink);
    end else begin
      t = int'(r.pulse_width) - c_center;
      if (c_reverse != 0) t = -t;
      if (absv(t) < absv(thr_prev) && absv(t - thr_prev) > m && absv(t) > m) begin
        ev_drop = 1'b1;
        ms_drop = 0;
      end
      if (absv(thr_prev) < m && absv(t) > m && t < 0) ev_brake = 1'b1;
      if (thr_prev > m && absv(t) < m) begin
        ev_fire = 1'b1;
        ms_fire = 0;
      end
      if (r.stop_blink_enable && !ev_idle && absv(t) < m) begin
        ms_idle = 0;
        ev_idle = 1'b1;
      end
      thr_prev = t;
    end

    t = thr_prev;
    // drop: tails on for the hold time
    if (ev_drop) begin
      lamp_q[LAMP_TAIL_L] = 1'b1;
      lamp_q[LAMP_TAIL_R] = 1'b1;
      if (ms_drop >= c_hold) begin
        if (!r.switch_on) lamp_q[LAMP_TAIL_L] = 1'b0;
        lamp_q[LAMP_TAIL_R] = 1'b0;
        ev_drop = 1'b0;
      end
    end
    // fire: on, off, on, then done
    if (ev_fire) begin
      if (ms_fire >= 3 * p) begin
        lamp_q[LAMP_FIRE] = 1'b0;
        ev_fire = 1'b0;
      end else begin
        lamp_q[LAMP_FIRE] = (ms_fire >= 2 * p) || (ms_fire < p);
      end
    end
    // idle at centre: wait, then blink the chassis lamp
    if (ev_idle) begin
      if (absv(t) > m || !r.stop_blink_enable) begin
        ev_idle = 1'b0;
        blink_on = 1'b0;
        lamp_q[LAMP_CHASSIS] = !r.stop_blink_enable && r.switch_on;
      end else if (ms_idle >= c_idle_wait && ms_blink >= c_blink) begin
        blink_on = !blink_on;
        lamp_q[LAMP_CHASSIS] = blink_on;
        ms_blink = 0;
      end
    end
    // brake: tails on until centre or forward
    if (ev_brake) begin
      lamp_q[LAMP_TAIL_L] = 1'b1;
      lamp_q[LAMP_TAIL_R] = 1'b1;
      if (absv(t) < m || t > m) begin
        if (!r.switch_on) lamp_q[LAMP_TAIL_L] = 1'b0;
        lamp_q[LAMP_TAIL_R] = 1'b0;
        ev_brake = 1'b0;
      end
    end

    y.lamps = lamp_q;
    y.throttle_value = THR_W'(thr_prev);
    y.active_events[EVT_DROP]  = ev_drop;
    y.active_events[EVT_BRAKE] = ev_brake;
    y.active_events[EVT_FIRE]  = ev_fire;
    y.active_events[EVT_IDLE]  = ev_idle;
    return y;
  endfunction

  function automatic tglc_item_t make_req(logic act, int pw, bit sw, bit en);
    tglc_item_t r;
    r.action = act;
    r.pulse_width = PW_W'(pw);
    r.switch_on = sw;
    r.stop_blink_enable = en;
    return r;
  endfunction

  // random request, grouped into bursts so that gestures actually form
  function automatic tglc_item_t rand_req();
    tglc_item_t r;
    int off, pw, cat;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 3);
      burst_cat = $urandom_range(3);
      case ($urandom_range(2))
        0: burst_tick_pct = 90;
        1: burst_tick_pct = 60;
        default: burst_tick_pct = 25;
      endcase
      burst_en_pct = ($urandom_range(3) == 0) ? 60 : 98;
    end
    burst_left--;
    r.switch_on = $urandom_range(1);
    r.stop_blink_enable = ($urandom_range(99) < burst_en_pct);
    r.pulse_width = $urandom_range(4095);
    r.action = ($urandom_range(99) < burst_tick_pct) ? ACT_TICK : ACT_SAMPLE;
    if (r.action == ACT_SAMPLE) begin
      cat = ($urandom_range(99) < 70) ? burst_cat : $urandom_range(3);
      case (cat)
        0: off = int'($urandom_range(2 * c_margin + 2)) - c_margin - 1;
        1: off = c_margin + 1 + int'($urandom_range(600));
        2: off = -c_margin - 1 - int'($urandom_range(600));
        default: off = int'(r.pulse_width) - c_center;
      endcase
      pw = c_center + off;
      if (pw < 0) pw = 0;
      if (pw > 4095) pw = 4095;
      r.pulse_width = PW_W'(pw);
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("[%0t] result %0d: %s is %0d, expected %0d",
               $time, results_checked, what, got, want);
  endtask

  task automatic add_row(logic act, int pw, bit sw, bit en, bit has_gold,
                         logic [LAMP_W-1:0] lamps, int thr, logic [EVT_W-1:0] evts);
    stim_row_t row;
    row.req = make_req(act, pw, sw, en);
    row.has_gold = has_gold;
    row.gold.lamps = lamps;
    row.gold.throttle_value = THR_W'(thr);
    row.gold.active_events = evts;
    stim_rows.push_back(row);
  endtask

  // offer one request and hold it until taken
  task automatic send_req(tglc_item_t r, bit use_gold, tglc_result_t g);
    s_tvalid <= 1'b1;
    s_tuser  <= r.action;
    s_tdata  <= {2'b00, r.stop_blink_enable, r.switch_on, r.pulse_width};
    gold_use <= use_gold;
    gold_now <= g;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic idle_gap();
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (results_checked < sent_count) @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    case (idx)
      REG_CENTER:     c_center    = int'(d[PW_W-1:0]);
      REG_MARGIN:     c_margin    = int'(d[MARGIN_W-1:0]);
      REG_REVERSE:    c_reverse   = int'(d[0]);
      REG_SHORT_HOLD: c_hold      = int'(d);
      REG_FIRE_PHASE: c_fire_ph   = int'(d[PHASE_W-1:0]);
      REG_IDLE_WAIT:  c_idle_wait = int'(d);
      REG_BLINK:      c_blink     = int'(d);
      default: ;
    endcase
  endtask

  // all seven registers plus the unused index; junk fills bits above each width
  task automatic program_settings(int ctr, int mg, int rev, int hold, int fph,
                                  int wt, int blk, bit junk);
    logic [CFG_DW-1:0] j;
    j = junk ? CFG_DW'($urandom()) : '0;
    set_reg(REG_CENTER,     CFG_DW'(ctr) | (j & 16'hF000));
    set_reg(REG_MARGIN,     CFG_DW'(mg)  | (j & 16'hFC00));
    set_reg(REG_REVERSE,    CFG_DW'(rev) | (j & 16'hFFFE));
    set_reg(REG_SHORT_HOLD, CFG_DW'(hold));
    set_reg(REG_FIRE_PHASE, CFG_DW'(fph) | (j & 16'hC000));
    set_reg(REG_IDLE_WAIT,  CFG_DW'(wt));
    set_reg(REG_BLINK,      CFG_DW'(blk));
    set_reg(REG_SPARE,      CFG_DW'($urandom_range(65535)));
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic run_random(int n, int idle_s, int stall_r, int hold_at, int pause_at);
    idle_pct = idle_s;
    stall_pct <= stall_r;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_reqs <= hold_reqs + 1;
      if (i == pause_at) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
      idle_gap();
      send_req(rand_req(), 1'b0, '0);
    end
  endtask

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // predict on each taken request, check each delivered result
  always @(posedge clk) begin : lamp_check
    tglc_result_t got, want;
    tglc_item_t   r;
    if (!rst) begin
      if (m_tvalid === 1'b1 && m_tready) begin
        got.lamps = m_tdata[3:0];
        got.throttle_value = m_tdata[16:4];
        got.active_events = m_tdata[20:17];
        if (lamp_results_due.size() == 0) begin
          flag_mismatch("result with no request pending", int'(m_tdata), 0);
        end else begin
          want = lamp_results_due.pop_front();
          if (got.lamps[LAMP_TAIL_L] !== want.lamps[LAMP_TAIL_L])
            flag_mismatch("tail_left", got.lamps[LAMP_TAIL_L], want.lamps[LAMP_TAIL_L]);
          if (got.lamps[LAMP_TAIL_R] !== want.lamps[LAMP_TAIL_R])
            flag_mismatch("tail_right", got.lamps[LAMP_TAIL_R], want.lamps[LAMP_TAIL_R]);
          if (got.lamps[LAMP_FIRE] !== want.lamps[LAMP_FIRE])
            flag_mismatch("fire_lamp", got.lamps[LAMP_FIRE], want.lamps[LAMP_FIRE]);
          if (got.lamps[LAMP_CHASSIS] !== want.lamps[LAMP_CHASSIS])
            flag_mismatch("chassis_lamp", got.lamps[LAMP_CHASSIS],
                          want.lamps[LAMP_CHASSIS]);
          if (got.throttle_value !== want.throttle_value)
            flag_mismatch("throttle_value", int'(got.throttle_value),
                          int'(want.throttle_value));
          if (got.active_events !== want.active_events)
            flag_mismatch("active_events", got.active_events, want.active_events);
        end
        results_checked++;
      end
      if (s_tvalid && s_tready === 1'b1) begin
        r.action = s_tuser;
        r.pulse_width = s_tdata[11:0];
        r.switch_on = s_tdata[12];
        r.stop_blink_enable = s_tdata[13];
        want = lamp_step(r);
        lamp_results_due.push_back(gold_use ? gold_now : want);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("throttle_gesture_light_controller regression: fail");
      $finish;
    end
  end

  initial begin
    // directed rows at reset settings; typed results only where obvious
    add_row(ACT_TICK,      0, 0, 0, 1, 4'b0000,     0, 4'b0000);
    add_row(ACT_SAMPLE, 1500, 0, 1, 1, 4'b0000,     0, 4'b1000);
    add_row(ACT_SAMPLE, 4095, 0, 1, 1, 4'b0000,  2595, 4'b0000);
    add_row(ACT_SAMPLE, 1500, 1, 0, 1, 4'b0100,     0, 4'b0100);
    add_row(ACT_SAMPLE,    0, 1, 0, 1, 4'b0111, -1500, 4'b0110);
    add_row(ACT_SAMPLE, 1000, 1, 0, 1, 4'b0111,  -500, 4'b0111);
    add_row(ACT_SAMPLE, 1520, 0, 1, 0, '0, 0, '0);
    add_row(ACT_SAMPLE, 1521, 0, 1, 0, '0, 0, '0);
    add_row(ACT_SAMPLE, 1479, 1, 1, 0, '0, 0, '0);
    add_row(ACT_SAMPLE, 1480, 1, 1, 0, '0, 0, '0);
    add_row(ACT_TICK,   4095, 1, 1, 0, '0, 0, '0);
    add_row(ACT_SAMPLE, 2800, 0, 1, 0, '0, 0, '0);
    add_row(ACT_SAMPLE, 1500, 0, 1, 0, '0, 0, '0);
    add_row(ACT_TICK,   2730, 0, 1, 0, '0, 0, '0);
    add_row(ACT_TICK,   1365, 1, 1, 0, '0, 0, '0);
    add_row(ACT_SAMPLE, 2000, 1, 1, 0, '0, 0, '0);
    add_row(ACT_SAMPLE, 1700, 1, 1, 0, '0, 0, '0);
    add_row(ACT_SAMPLE, 1200, 0, 1, 0, '0, 0, '0);
    add_row(ACT_TICK,      0, 0, 0, 0, '0, 0, '0);
    add_row(ACT_SAMPLE, 1500, 1, 0, 0, '0, 0, '0);
    add_row(ACT_TICK,      0, 1, 1, 0, '0, 0, '0);
    add_row(ACT_TICK,      0, 0, 1, 0, '0, 0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) send_req(stim_rows[i].req, stim_rows[i].has_gold, stim_rows[i].gold);
    settle();

    // nominal centre, short timers, no idling, long receiver hold-off
    program_settings(1500, 20, 0, 5, 3, 10, 2, 0);
    run_random(240, 0, 0, 60, -1);
    settle();

    // reversed, zero timers expire at once, sender idles
    program_settings(2048, 100, 1, 0, 0, 0, 0, 0);
    run_random(240, 80, 0, -1, -1);
    settle();

    // centre at the bottom, widest margin, receiver stalls, sender pauses mid-way
    program_settings(0, 1023, 0, 12, 4, 3, 1, 0);
    run_random(240, 0, 80, -1, 120);
    settle();

    // centre at the top, zero margin, reversed, both sides idle a little
    program_settings(4095, 0, 1, 7, 2, 5, 3, 0);
    run_random(240, 9, 9, -1, -1);
    settle();

    // random settings, junk above each register width
    program_settings($urandom_range(2800, 1200), $urandom_range(80), $urandom_range(1),
                     $urandom_range(30), $urandom_range(10), $urandom_range(40),
                     $urandom_range(8), 1);
    run_random(240, 0, 0, -1, -1);
    settle();

    // largest timers
    program_settings(1500, 1023, 1, 65535, 16383, 65535, 65535, 0);
    run_random(200, 9, 9, -1, -1);
    settle();

    // unbroken tick run: drop hold and fire pattern run out, chassis lamp blinks
    program_settings(1500, 20, 0, 30, 8, 20, 2, 0);
    idle_pct = 0;
    stall_pct <= 0;
    send_req(make_req(ACT_SAMPLE, 2500, 0, 1), 1'b0, '0);
    send_req(make_req(ACT_SAMPLE, 1600, 0, 1), 1'b0, '0);
    send_req(make_req(ACT_SAMPLE, 1500, 1, 1), 1'b0, '0);
    for (int i = 0; i < TICK_RUN; i++)
      send_req(make_req(ACT_TICK, $urandom_range(4095), $urandom_range(1), 1), 1'b0, '0);
    settle();

    if (lamp_results_due.size() != 0)
      flag_mismatch("results never delivered", lamp_results_due.size(), 0);

    $display("%0d requests over %0d register settings, %0d results compared field by field",
             sent_count, settings_count, results_checked);
    $display("gestures, zero and full-scale timers, timer expiry and blinking, %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("throttle_gesture_light_controller regression: pass");
    end else begin
      $display("throttle_gesture_light_controller regression: fail");
    end
    $finish;
  end

endmodule

@@ throttle_gesture_light_controller.f @@
rtl/tglc_pkg.sv
rtl/tglc_cfg.sv
rtl/tglc_core.sv
rtl/throttle_gesture_light_controller.sv
verif/tb_throttle_gesture_light_controller.sv
